// ===== src/tnept_pkg.sv =====
// Shared types and constants of the top-N extrema position tracker.
package tnept_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W = 33;
  localparam int unsigned PORT_COORD_W = 16;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned RANK_W = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned ENTRIES_W = 7;

  // Command queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // Clear value in min mode: largest 33-bit two's complement value
  localparam logic signed [VALUE_W-1:0] FILL_MIN = 33'sh0_FFFF_FFFF;
  localparam logic signed [VALUE_W-1:0] FILL_MAX = '0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIND_MINIMA = 1'd1;

  // Command codes
  typedef enum logic [FUNC_W-1:0] {
    OP_OFFER = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Back end states
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

  // One queued command
  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
    logic [PORT_COORD_W-1:0]    x;
    logic [PORT_COORD_W-1:0]    y;
  } cmd_t;

  // Mode and list length seen by the back end
  typedef struct packed {
    logic find_minima;
    logic [ENTRIES_W-1:0] last_idx;
  } list_ctrl_t;

endpackage

// ===== src/top_n_extrema_position_tracker.sv =====
// Top level of the top-N extrema position tracker.
// Keeps up to MAX_ENTRIES strongest pixels (value and x,y) in rank order. A command is
// taken when start is high and busy is low; commands wait in a two-entry queue and
// busy is high only while that queue is full. The back end applies an offer or a clear
// straight from its idle state; a read out first takes the command, then reads out n
// entries, where n is entries_in_use limited to 1..MAX_ENTRIES; an unused code is
// dropped on entry. An offer compares against all ranked cells at once. A read out
// returns one entry per cycle, strongest first, each held for exactly one cycle with
// out_valid high and out_last on the final one; the receiver cannot stall them.
// Configuration writes belong to idle periods with no read out pending.
module top_n_extrema_position_tracker
  import tnept_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic signed [VALUE_W-1:0]  in_sample_value,
  input  logic [PORT_COORD_W-1:0]    in_pos_x,
  input  logic [PORT_COORD_W-1:0]    in_pos_y,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  output logic                       out_valid,
  output logic [RANK_W-1:0]          out_rank,
  output logic [PORT_COORD_W-1:0]    out_x,
  output logic [PORT_COORD_W-1:0]    out_y,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic                       out_last
);

  logic [ENTRIES_W-1:0] entries_r;
  logic                 minima_r;
  logic [ENTRIES_W-1:0] active;
  list_ctrl_t           ctrl;
  logic                 cmd_valid;
  logic                 cmd_ready;
  cmd_t                 cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= ENTRIES_W'(16);
      minima_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRIES_IN_USE: entries_r <= cfg_wdata[ENTRIES_W-1:0];
        CFG_FIND_MINIMA:    minima_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Active list length, clamped to 1..MAX_ENTRIES
  always_comb begin
    if (entries_r == '0) begin
      active = ENTRIES_W'(1);
    end else if (entries_r > ENTRIES_W'(MAX_ENTRIES)) begin
      active = ENTRIES_W'(MAX_ENTRIES);
    end else begin
      active = entries_r;
    end
    ctrl.find_minima = minima_r;
    ctrl.last_idx    = active - 1'b1;
  end

  tnept_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_sample_value (in_sample_value),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_ready       (cmd_ready)
  );

  tnept_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .ctrl      (ctrl),
    .out_valid (out_valid),
    .out_rank  (out_rank),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

// ===== src/tnept_front.sv =====
// Front end: takes commands, drops unused codes and queues the rest.
module tnept_front
  import tnept_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic signed [VALUE_W-1:0]  in_sample_value,
  input  logic [PORT_COORD_W-1:0]    in_pos_x,
  input  logic [PORT_COORD_W-1:0]    in_pos_y,
  output logic                       cmd_valid,
  output cmd_t                       cmd,
  input  logic                       cmd_ready
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             known;
  logic             push;
  logic             pop;
  cmd_t             new_cmd;

  // Classify the transaction: only defined codes reach the queue
  always_comb begin
    case (in_func)
      OP_OFFER, OP_CLEAR, OP_READ: known = 1'b1;
      default: known = 1'b0;
    endcase
    new_cmd.op    = op_t'(in_func);
    new_cmd.value = in_sample_value;
    new_cmd.x     = in_pos_x;
    new_cmd.y     = in_pos_y;
  end

  assign busy      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign accept    = start && !busy;
  assign push      = accept && known;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue_r[rd_ptr_r];

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ===== src/tnept_back.sv =====
// Back end: ranked cell row that inserts, clears and reads out the kept extrema.
module tnept_back
  import tnept_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  cmd_t                       cmd,
  output logic                       cmd_ready,
  input  list_ctrl_t                 ctrl,
  output logic                       out_valid,
  output logic [RANK_W-1:0]          out_rank,
  output logic [PORT_COORD_W-1:0]    out_x,
  output logic [PORT_COORD_W-1:0]    out_y,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic                       out_last
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Cell row, index 0 strongest
  logic signed [VALUE_W-1:0] val_r [MAX_ENTRIES];
  logic [COORD_BITS-1:0]     x_r   [MAX_ENTRIES];
  logic [COORD_BITS-1:0]     y_r   [MAX_ENTRIES];
  logic signed [VALUE_W-1:0] val_nxt [MAX_ENTRIES];
  logic [COORD_BITS-1:0]     x_nxt   [MAX_ENTRIES];
  logic [COORD_BITS-1:0]     y_nxt   [MAX_ENTRIES];

  back_state_t state_r, state_nxt;
  logic [IDX_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [IDX_W-1:0] last_idx;
  logic [MAX_ENTRIES-1:0] beats;
  logic [MAX_ENTRIES-1:0] above;
  logic accept;
  logic do_offer;
  logic do_clear;
  logic rotate;
  logic rd_last;

  logic                       out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0]          out_rank_r;
  logic [PORT_COORD_W-1:0]    out_x_r;
  logic [PORT_COORD_W-1:0]    out_y_r;
  logic signed [VALUE_W-1:0]  out_value_r;
  logic                       out_last_r;

  assign last_idx = ctrl.last_idx[IDX_W-1:0];

  // Per-cell compare of the offered sample and prefix of stronger cells
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      beats[i] = ctrl.find_minima ? (cmd.value < val_r[i]) : (cmd.value > val_r[i]);
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      above[i] = |(beats & ((MAX_ENTRIES'(1) << i) - MAX_ENTRIES'(1)));
    end
  end

  assign accept = beats[last_idx];

  // Sequencer: offers and clears act in idle; a read out moves one entry per cycle
  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    cmd_ready  = 1'b0;
    do_offer   = 1'b0;
    do_clear   = 1'b0;
    rotate     = 1'b0;
    rd_last    = (rd_cnt_r == last_idx);
    case (state_r)
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (cmd.op)
            OP_OFFER: do_offer = 1'b1;
            OP_CLEAR: do_clear = 1'b1;
            OP_READ: begin
              state_nxt  = BK_READ;
              rd_cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        rotate = 1'b1;
        if (rd_last) begin
          state_nxt = BK_IDLE;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Next contents of each cell
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      val_nxt[i] = val_r[i];
      x_nxt[i]   = x_r[i];
      y_nxt[i]   = y_r[i];
      if (do_clear) begin
        val_nxt[i] = ctrl.find_minima ? FILL_MIN : FILL_MAX;
        x_nxt[i]   = '0;
        y_nxt[i]   = '0;
      end else if (do_offer && accept && (IDX_W'(i) <= last_idx)) begin
        if (above[i]) begin
          val_nxt[i] = val_r[(i > 0) ? i - 1 : 0];
          x_nxt[i]   = x_r[(i > 0) ? i - 1 : 0];
          y_nxt[i]   = y_r[(i > 0) ? i - 1 : 0];
        end else if (beats[i]) begin
          val_nxt[i] = cmd.value;
          x_nxt[i]   = COORD_BITS'(cmd.x);
          y_nxt[i]   = COORD_BITS'(cmd.y);
        end
      end else if (rotate && (IDX_W'(i) <= last_idx)) begin
        // Circular shift toward cell 0 over the active length
        if (IDX_W'(i) == last_idx) begin
          val_nxt[i] = val_r[0];
          x_nxt[i]   = x_r[0];
          y_nxt[i]   = y_r[0];
        end else begin
          val_nxt[i] = val_r[(i + 1 < MAX_ENTRIES) ? i + 1 : i];
          x_nxt[i]   = x_r[(i + 1 < MAX_ENTRIES) ? i + 1 : i];
          y_nxt[i]   = y_r[(i + 1 < MAX_ENTRIES) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        val_r[i] <= '0;
        x_r[i]   <= '0;
        y_r[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        val_r[i] <= val_nxt[i];
        x_r[i]   <= x_nxt[i];
        y_r[i]   <= y_nxt[i];
      end
    end
  end

  // Control state
  assign out_valid_nxt = rotate;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register, loaded from the head cell
  always_ff @(posedge clk) begin
    if (rotate) begin
      out_rank_r  <= RANK_W'(rd_cnt_r);
      out_x_r     <= PORT_COORD_W'(x_r[0]);
      out_y_r     <= PORT_COORD_W'(y_r[0]);
      out_value_r <= val_r[0];
      out_last_r  <= rd_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rank  = out_rank_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule
